@@ rtl/u8flc_pkg.sv @@
// Package for the UTF-8 framer with line and column tracking.
// Holds the widths, byte class constants, status codes and shared structs.
// No dependencies; compile first.
`default_nettype none

package u8flc_pkg;

    localparam int LINE_BITS   = 24;
    localparam int COLUMN_BITS = 16;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [31:0] BOM_BYTES = 32'h00EF_BBBF;

    localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = {COLUMN_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_BAD_CONT  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]             expected_length;
        logic [2:0]             bytes_collected;
        logic [23:0]            partial_bytes;
        logic [LINE_BITS-1:0]   line_counter;
        logic [COLUMN_BITS-1:0] column_counter;
        logic                   pending_cr;
        logic                   awaiting_first_char;
        logic                   error_stuck;
    } state_t;

    typedef struct packed {
        logic [31:0]            char_bytes;
        logic [2:0]             char_length;
        logic [1:0]             status;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/u8flc_text_if.sv @@
// Byte channel into the framer: valid/ready with one raw byte per beat.
// No dependencies.
`default_nettype none

interface u8flc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_mark;

    modport source (output valid, output data_byte, output end_mark, input ready);
    modport sink   (input valid, input data_byte, input end_mark, output ready);
endinterface

`default_nettype wire

@@ rtl/u8flc_char_if.sv @@
// Character channel out of the framer: valid/ready with one character per beat.
// Depends on u8flc_pkg for the counter widths.
`default_nettype none

interface u8flc_char_if;
    logic                              valid;
    logic                              ready;
    logic [31:0]                       char_bytes;
    logic [2:0]                        char_length;
    logic [1:0]                        status;
    logic [u8flc_pkg::LINE_BITS-1:0]   line_number;
    logic [u8flc_pkg::COLUMN_BITS-1:0] column_number;

    modport source (output valid, output char_bytes, output char_length, output status,
                    output line_number, output column_number, input ready);
    modport sink   (input valid, input char_bytes, input char_length, input status,
                    input line_number, input column_number, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8_framer_line_column_top.sv @@
// Top level of the UTF-8 framer with line and column tracking.
// Depends on u8flc_pkg, u8flc_text_if, u8flc_char_if and u8flc_decode.
`default_nettype none

// One byte beat is taken per clock cycle while the byte channel is ready. The framing
// state and the line and column counters update at the edge that accepts the byte,
// and any character or error it completes is loaded into the result register at that
// same edge. The byte channel is ready whenever the result register is empty or is
// being taken in the same cycle, so an unstalled stream runs at one byte per cycle.
// Results carry the line and column of the next character; an error is sticky
// until reset, and while it holds every byte is accepted and dropped.
module utf8_framer_line_column_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    u8flc_text_if.sink        text,
    u8flc_char_if.source      chars
);
    import u8flc_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    logic    emit;
    result_t result;
    result_t result_reg;
    logic    valid_reg;
    logic    take;

    assign text.ready = !valid_reg || chars.ready;
    assign take       = text.valid && text.ready;

    u8flc_decode u_decode (
        .state      (state_reg),
        .data_byte  (text.data_byte),
        .end_mark   (text.end_mark),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.expected_length     <= 3'd0;
            state_reg.bytes_collected     <= 3'd0;
            state_reg.partial_bytes       <= 24'd0;
            state_reg.line_counter        <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            state_reg.column_counter      <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            state_reg.pending_cr          <= 1'b0;
            state_reg.awaiting_first_char <= 1'b1;
            state_reg.error_stuck         <= 1'b0;
            valid_reg                     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
                valid_reg <= emit;
            end
            else if (chars.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload: load only when a new result lands
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            result_reg <= result;
        end
    end

    assign chars.valid         = valid_reg;
    assign chars.char_bytes    = result_reg.char_bytes;
    assign chars.char_length   = result_reg.char_length;
    assign chars.status        = result_reg.status;
    assign chars.line_number   = result_reg.line_number;
    assign chars.column_number = result_reg.column_number;

endmodule

`default_nettype wire

@@ rtl/u8flc_decode.sv @@
// Per-beat decode: byte classing, sequence assembly, newline and BOM handling,
// counter update. Purely combinational. Depends on u8flc_pkg.
`default_nettype none

module u8flc_decode (
    input  wire u8flc_pkg::state_t  state,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_mark,
    output u8flc_pkg::state_t       state_next,
    output logic                    emit,
    output u8flc_pkg::result_t      result
);
    import u8flc_pkg::*;

    logic        fin;
    logic [31:0] fin_bytes;
    logic [2:0]  fin_len;
    logic [31:0] acc;
    logic [2:0]  cnt;
    logic        is_cr;
    logic        is_lf;

    assign acc = {state.partial_bytes, data_byte};
    assign cnt = state.bytes_collected + 3'd1;

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        fin        = 1'b0;
        fin_bytes  = 32'd0;
        fin_len    = 3'd0;
        result.char_bytes  = 32'd0;
        result.char_length = 3'd0;
        result.status      = ST_OK;
        is_cr = 1'b0;
        is_lf = 1'b0;

        if (!state.error_stuck)
        begin
            if (end_mark)
            begin
                if (state.expected_length != 3'd0)
                begin
                    emit          = 1'b1;
                    result.status = ST_TRUNCATED;
                end
            end
            else if (state.expected_length == 3'd0)
            begin
                if (!data_byte[7])
                begin
                    fin       = 1'b1;
                    fin_bytes = {24'd0, data_byte};
                    fin_len   = 3'd1;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    state_next.expected_length = 3'd2;
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    state_next.expected_length = 3'd3;
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    state_next.expected_length = 3'd4;
                end
                else
                begin
                    emit          = 1'b1;
                    result.status = ST_BAD_LEAD;
                end
                if (data_byte[7] && !emit)
                begin
                    state_next.partial_bytes   = {16'd0, data_byte};
                    state_next.bytes_collected = 3'd1;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                emit          = 1'b1;
                result.status = ST_BAD_CONT;
            end
            else if (cnt >= state.expected_length)
            begin
                fin       = 1'b1;
                fin_bytes = acc;
                fin_len   = state.expected_length;
                state_next.expected_length = 3'd0;
                state_next.bytes_collected = 3'd0;
                state_next.partial_bytes   = 24'd0;
            end
            else
            begin
                state_next.partial_bytes   = acc[23:0];
                state_next.bytes_collected = cnt;
            end

            // any error result sticks and drops the pending sequence
            if (emit)
            begin
                state_next.error_stuck     = 1'b1;
                state_next.expected_length = 3'd0;
                state_next.bytes_collected = 3'd0;
                state_next.partial_bytes   = 24'd0;
            end

            if (fin)
            begin
                is_cr = (fin_len == 3'd1) && (fin_bytes[7:0] == BYTE_CR);
                is_lf = (fin_len == 3'd1) && (fin_bytes[7:0] == BYTE_LF);
                if (is_cr || (is_lf && !state.pending_cr))
                begin
                    if (state.line_counter != LINE_MAX)
                    begin
                        state_next.line_counter = state.line_counter + LINE_BITS'(1);
                    end
                    state_next.column_counter = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
                    state_next.pending_cr     = is_cr;
                    emit = 1'b1;
                end
                else if (is_lf)
                begin
                    // LF of a CR-LF pair: drop
                    state_next.pending_cr = 1'b0;
                end
                else
                begin
                    state_next.pending_cr          = 1'b0;
                    state_next.awaiting_first_char = 1'b0;
                    if (!(state.awaiting_first_char && fin_len == 3'd3
                          && fin_bytes == BOM_BYTES))
                    begin
                        if (state.column_counter != COLUMN_MAX)
                        begin
                            state_next.column_counter = state.column_counter
                                                        + COLUMN_BITS'(1);
                        end
                        emit = 1'b1;
                    end
                end
                result.char_bytes  = fin_bytes;
                result.char_length = fin_len;
            end
        end

        result.line_number   = state_next.line_counter;
        result.column_number = state_next.column_counter;
    end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for utf8_framer_line_column_top: byte beats in, character beats out.
// A directed script runs first, then random well-formed text, an unstalled tail and a fault.
// Depends on u8flc_pkg, u8flc_text_if, u8flc_char_if and the framer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u8flc_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       end_mark;
        bit         typed;
        result_t    want;
    } text_row_t;

    logic clk;
    logic rst_n;

    u8flc_text_if text_bus ();
    u8flc_char_if char_bus ();

    utf8_framer_line_column_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_bus),
        .chars (char_bus)
    );

    // Framing state of the predictor
    logic [2:0]             want_len;
    logic [2:0]             got_len;
    logic [23:0]            partial;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [COLUMN_BITS-1:0] col_cnt;
    bit                     cr_pending;
    bit                     first_char_pending;
    bit                     stuck;

    text_row_t script[$];
    result_t   chars_due[$];
    int        beats_taken = 0;
    int        bytes_sent = 0;
    int        mismatches = 0;
    bit        stall_enable = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic next_line();
        if (line_cnt != LINE_MAX)
            line_cnt++;
        col_cnt = COLUMN_BITS'(1);
    endtask

    task automatic raise_fault(input status_t code, output bit produced, output result_t res);
        stuck    = 1'b1;
        want_len = '0;
        got_len  = '0;
        partial  = '0;
        produced = 1'b1;
        res               = '0;
        res.status        = code;
        res.line_number   = line_cnt;
        res.column_number = col_cnt;
    endtask

    task automatic close_char(input logic [31:0] bytes, input logic [2:0] len,
                              output bit produced, output result_t res);
        produced = 1'b0;
        res      = '0;
        if (len == 3'd1 && bytes == BYTE_CR)
        begin
            next_line();
            cr_pending = 1'b1;
        end
        else if (len == 3'd1 && bytes == BYTE_LF)
        begin
            // LF of a CR-LF pair: swallow it
            if (cr_pending)
            begin
                cr_pending = 1'b0;
                return;
            end
            next_line();
        end
        else
        begin
            cr_pending = 1'b0;
            if (first_char_pending)
            begin
                first_char_pending = 1'b0;
                // drop a byte order mark at the start of the text
                if (len == 3'd3 && bytes == BOM_BYTES)
                    return;
            end
            if (col_cnt != COLUMN_MAX)
                col_cnt++;
        end
        produced          = 1'b1;
        res.char_bytes    = bytes;
        res.char_length   = len;
        res.status        = ST_OK;
        res.line_number   = line_cnt;
        res.column_number = col_cnt;
    endtask

    task automatic frame_byte(input logic [7:0] b, input logic fin,
                              output bit produced, output result_t res);
        logic [31:0] acc;
        logic [2:0]  len;
        produced = 1'b0;
        res      = '0;
        if (stuck)
            return;
        if (fin)
        begin
            if (want_len != 0)
                raise_fault(ST_TRUNCATED, produced, res);
            return;
        end
        if (want_len == 0)
        begin
            if (b < 8'h80)
            begin
                close_char({24'h0, b}, 3'd1, produced, res);
                return;
            end
            if (b >= 8'hC0 && b <= 8'hDF)
                want_len = 3'd2;
            else if (b >= 8'hE0 && b <= 8'hEF)
                want_len = 3'd3;
            else if (b >= 8'hF0 && b <= 8'hF7)
                want_len = 3'd4;
            else
            begin
                raise_fault(ST_BAD_LEAD, produced, res);
                return;
            end
            partial = {16'h0, b};
            got_len = 3'd1;
            return;
        end
        if (b < 8'h80 || b > 8'hBF)
        begin
            raise_fault(ST_BAD_CONT, produced, res);
            return;
        end
        acc = {partial, b};
        got_len++;
        if (got_len >= want_len)
        begin
            len      = want_len;
            want_len = '0;
            got_len  = '0;
            partial  = '0;
            close_char(acc, len, produced, res);
        end
        else
            partial = acc[23:0];
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : char_check
        result_t want;
        result_t predicted;
        bit      produced;
        if (rst_n)
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                if (chars_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: character expected none, got %h length %0d status %0d",
                             $time, char_bus.char_bytes, char_bus.char_length,
                             char_bus.status);
                end
                else
                begin
                    want = chars_due.pop_front();
                    check_field("char_bytes", want.char_bytes, char_bus.char_bytes);
                    check_field("char_length", want.char_length, char_bus.char_length);
                    check_field("status", want.status, char_bus.status);
                    check_field("line_number", want.line_number, char_bus.line_number);
                    check_field("column_number", want.column_number, char_bus.column_number);
                end
            end
            if (text_bus.valid && text_bus.ready)
            begin
                frame_byte(text_bus.data_byte, text_bus.end_mark, produced, predicted);
                // scripted rows with a typed result take it over the prediction
                if (beats_taken < script.size() && script[beats_taken].typed)
                    chars_due.push_back(script[beats_taken].want);
                else if (produced)
                    chars_due.push_back(predicted);
                beats_taken++;
            end
        end
    end

    initial
    begin : char_sink
        forever
        begin
            if (stall_enable && $urandom_range(0, 5) == 0)
            begin
                char_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            char_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic add_row(input logic [7:0] b, input logic fin, input bit typed,
                           input int line, input int col);
        text_row_t row;
        row.data_byte = b;
        row.end_mark  = fin;
        row.typed     = typed;
        row.want      = '0;
        if (typed)
        begin
            row.want.char_bytes    = {24'h0, b};
            row.want.char_length   = 3'd1;
            row.want.status        = ST_OK;
            row.want.line_number   = LINE_BITS'(line);
            row.want.column_number = COLUMN_BITS'(col);
        end
        script.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (stall_enable && $urandom_range(0, 5) == 0)
        begin
            text_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        text_bus.valid     <= 1'b1;
        text_bus.data_byte <= b;
        text_bus.end_mark  <= fin;
        @(posedge clk);
        while (!text_bus.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] lead_for(input int n);
        case (n)
            2:       return {3'b110, 5'($urandom_range(0, 31))};
            3:       return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 7))};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic send_random_char();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_byte(BYTE_CR, 1'b0);
        else if (pick < 22)
            send_byte(BYTE_LF, 1'b0);
        else if (pick < 30)
        begin
            send_byte(BYTE_CR, 1'b0);
            send_byte(BYTE_LF, 1'b0);
        end
        else if (pick < 34)
            send_byte(8'($urandom), 1'b1);
        else if (pick < 60)
            send_byte(8'($urandom_range(0, 127)), 1'b0);
        else
        begin
            n = (pick < 75) ? 2 : (pick < 88) ? 3 : 4;
            send_byte(lead_for(n), 1'b0);
            repeat (n - 1) send_byte(cont_byte(), 1'b0);
        end
    endtask

    initial
    begin : stimulus
        status_t fault;
        int      n;
        int      waited;
        int      random_end;
        bit      paused;

        rst_n              <= 1'b0;
        text_bus.valid     <= 1'b0;
        text_bus.data_byte <= 8'h00;
        text_bus.end_mark  <= 1'b0;

        want_len           = '0;
        got_len            = '0;
        partial            = '0;
        line_cnt           = LINE_BITS'(1);
        col_cnt            = COLUMN_BITS'(1);
        cr_pending         = 1'b0;
        first_char_pending = 1'b1;
        stuck              = 1'b0;
        paused             = 1'b0;

        // newlines first: they must not count as the first character
        add_row(BYTE_CR, 1'b0, 1'b1, 2, 1);
        add_row(BYTE_LF, 1'b0, 1'b0, 0, 0);
        add_row(BYTE_LF, 1'b0, 1'b1, 3, 1);
        add_row(8'hA5, 1'b1, 1'b0, 0, 0);
        // byte order mark, dropped
        add_row(8'hEF, 1'b0, 1'b0, 0, 0);
        add_row(8'hBB, 1'b0, 1'b0, 0, 0);
        add_row(8'hBF, 1'b0, 1'b0, 0, 0);
        add_row(8'h00, 1'b0, 1'b1, 3, 2);
        add_row(8'hC2, 1'b0, 1'b0, 0, 0);
        add_row(8'h80, 1'b0, 1'b0, 0, 0);
        add_row(8'hDF, 1'b0, 1'b0, 0, 0);
        add_row(8'hBF, 1'b0, 1'b0, 0, 0);
        // a second mark is an ordinary character
        add_row(8'hEF, 1'b0, 1'b0, 0, 0);
        add_row(8'hBB, 1'b0, 1'b0, 0, 0);
        add_row(8'hBF, 1'b0, 1'b0, 0, 0);
        add_row(8'hF0, 1'b0, 1'b0, 0, 0);
        add_row(8'h80, 1'b0, 1'b0, 0, 0);
        add_row(8'h80, 1'b0, 1'b0, 0, 0);
        add_row(8'h80, 1'b0, 1'b0, 0, 0);
        add_row(8'hF7, 1'b0, 1'b0, 0, 0);
        add_row(8'hBF, 1'b0, 1'b0, 0, 0);
        add_row(8'hBF, 1'b0, 1'b0, 0, 0);
        add_row(8'hBF, 1'b0, 1'b0, 0, 0);
        // CR then a plain character clears the pending CR, so the LF counts
        add_row(BYTE_CR, 1'b0, 1'b1, 4, 1);
        add_row(8'h7F, 1'b0, 1'b1, 4, 2);
        add_row(BYTE_LF, 1'b0, 1'b1, 5, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_byte(script[i].data_byte, script[i].end_mark);

        random_end = bytes_sent + 420;
        while (bytes_sent < random_end)
        begin
            if ($urandom_range(0, 29) == 0)
                stall_enable = ($urandom_range(0, 2) != 0);
            if (!paused && bytes_sent >= random_end - 250)
            begin
                // hold the stream until every character has drained
                paused = 1'b1;
                text_bus.valid <= 1'b0;
                repeat (2) @(posedge clk);
                while (chars_due.size() != 0)
                    @(posedge clk);
            end
            send_random_char();
        end

        // no idling from here on
        stall_enable = 1'b0;
        repeat (40) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);

        // close with one fault, then bytes that the stuck framer must drop
        fault = status_t'($urandom_range(1, 3));
        n     = $urandom_range(2, 4);
        case (fault)
            ST_BAD_LEAD:
                send_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                      : 8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
            ST_BAD_CONT:
            begin
                send_byte(lead_for(n), 1'b0);
                repeat ($urandom_range(0, n - 2)) send_byte(cont_byte(), 1'b0);
                send_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8'h7F))
                                                      : 8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
            end
            ST_TRUNCATED:
            begin
                send_byte(lead_for(n), 1'b0);
                repeat ($urandom_range(0, n - 2)) send_byte(cont_byte(), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
            default: ;
        endcase
        repeat (8) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        text_bus.valid <= 1'b0;

        waited = 0;
        while (chars_due.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);

        if (chars_due.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: %0d characters expected, none arrived", $time, chars_due.size());
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
